// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- src/rbcf_pkg.sv -----
`default_nettype none

package rbcf_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int FRAC_W      = 16;
  localparam int LIMIT_W     = FRAC_W + 1;
  localparam int PROD_W      = LIMIT_W + LENGTH_BITS;
  localparam int NUM_CLS     = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W  = LIMIT_W;
  localparam int REG_INDEX_W = 3;

  typedef logic [2:0] class_t;
  localparam class_t CLS_A = 3'd0;
  localparam class_t CLS_C = 3'd1;
  localparam class_t CLS_G = 3'd2;
  localparam class_t CLS_T = 3'd3;
  localparam class_t CLS_N = 3'd4;

  localparam logic [7:0] CHAR_A  = 8'h41;
  localparam logic [7:0] CHAR_C  = 8'h43;
  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_T  = 8'h54;
  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LC = 8'h63;
  localparam logic [7:0] CHAR_LG = 8'h67;
  localparam logic [7:0] CHAR_LT = 8'h74;

  typedef logic [REG_INDEX_W-1:0] reg_index_t;
  localparam reg_index_t REG_LIMIT_A       = 3'd0;
  localparam reg_index_t REG_LIMIT_C       = 3'd1;
  localparam reg_index_t REG_LIMIT_G       = 3'd2;
  localparam reg_index_t REG_LIMIT_T       = 3'd3;
  localparam reg_index_t REG_LIMIT_N       = 3'd4;
  localparam reg_index_t REG_QUALITY_SHIFT = 3'd5;

  localparam logic [LIMIT_W-1:0] LIMIT_ACGT_RESET = 17'd58982;
  localparam logic [LIMIT_W-1:0] LIMIT_N_RESET    = 17'd6554;

  typedef struct packed {
    logic [7:0] base_char;
    logic [7:0] quality_char;
    logic       read_end;
  } item_t;

  typedef struct packed {
    logic [7:0]  base_out;
    logic [7:0]  quality_out;
    logic        read_done;
    logic        keep_read;
    logic [31:0] read_number;
    logic [31:0] dropped_total;
  } result_t;

  // limit[i] belongs to class code i
  typedef struct packed {
    logic [NUM_CLS-1:0][LIMIT_W-1:0] limit;
    logic signed [7:0]               quality_shift;
  } cfg_t;

  typedef struct packed {
    class_t     cls;
    logic [7:0] quality;
    logic       last;
  } entry_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t cls;
    unique case (c) inside
      CHAR_A, CHAR_LA: cls = CLS_A;
      CHAR_C, CHAR_LC: cls = CLS_C;
      CHAR_G, CHAR_LG: cls = CLS_G;
      CHAR_T, CHAR_LT: cls = CLS_T;
      default:         cls = CLS_N;
    endcase
    return cls;
  endfunction

  function automatic logic [7:0] class_char(input class_t cls);
    logic [7:0] c;
    unique case (cls)
      CLS_A:   c = CHAR_A;
      CLS_C:   c = CHAR_C;
      CLS_G:   c = CHAR_G;
      CLS_T:   c = CHAR_T;
      default: c = CHAR_N;
    endcase
    return c;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc_len(input logic [LENGTH_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- src/read_base_composition_filter_top.sv -----
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-----------------------------------
//  item     | in  | item_valid / item_stall    | item_t: base, quality, read_end
//  result   | out | result_valid / result_stall| result_t: base, quality, verdict
//  config   | in  | wr_en (no handshake back)  | wr_index, wr_data
//
//  One item per cycle sustained while no result stall backs up; each item
//  yields one result, registered in the queue, then the accumulate, multiply
//  and output stages. The five limit-by-length multiplies sit in their own
//  stage; throughput is set by the per-item count update.
//  Synchronous active-high reset clears counts, totals and all valid flags.
//  A result stall backs up through the pipeline and the 4-entry queue
//  before item_stall rises.
`default_nettype none
`include "assert_macros.svh"

module read_base_composition_filter_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input items
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire rbcf_pkg::item_t                     item,
  // results
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output rbcf_pkg::result_t                        result,
  // configuration writes
  input  wire logic                                wr_en,
  input  wire logic [rbcf_pkg::REG_INDEX_W-1:0]    wr_index,
  input  wire logic [rbcf_pkg::CFG_DATA_W-1:0]     wr_data
);
  import rbcf_pkg::*;

  cfg_t   cfg;
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  // Register file. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit[CLS_A]  <= LIMIT_ACGT_RESET;
      cfg.limit[CLS_C]  <= LIMIT_ACGT_RESET;
      cfg.limit[CLS_G]  <= LIMIT_ACGT_RESET;
      cfg.limit[CLS_T]  <= LIMIT_ACGT_RESET;
      cfg.limit[CLS_N]  <= LIMIT_N_RESET;
      cfg.quality_shift <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LIMIT_A:       cfg.limit[CLS_A]  <= wr_data;
        REG_LIMIT_C:       cfg.limit[CLS_C]  <= wr_data;
        REG_LIMIT_G:       cfg.limit[CLS_G]  <= wr_data;
        REG_LIMIT_T:       cfg.limit[CLS_T]  <= wr_data;
        REG_LIMIT_N:       cfg.limit[CLS_N]  <= wr_data;
        REG_QUALITY_SHIFT: cfg.quality_shift <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  // front: classify base, shift quality, push into the queue
  rbcf_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // decouples input stalls from the counting pipeline
  rbcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back: per-read counts, verdict, read and drop totals, output register
  rbcf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // verdict only on the last base of a read
  `ASSERT_IMPLIES(a_keep_only_on_done, clk, rst, result_valid && !result.read_done, !result.keep_read)
  // drops never outnumber reads
  `ASSERT_IMPLIES(a_drops_bounded, clk, rst, result_valid, result.dropped_total <= result.read_number)
  // a dropped read is counted in the running total
  `ASSERT_IMPLIES(a_drop_counted, clk, rst, result_valid && result.read_done && !result.keep_read, result.dropped_total != 32'd0)
  // read number holds within a read
  `ASSERT_NEXT(a_number_holds, clk, rst, result_valid && !result_stall && !result.read_done, !result_valid || result.read_number == $past(result.read_number))
  // read number steps after a read ends
  `ASSERT_NEXT(a_number_steps, clk, rst, result_valid && !result_stall && result.read_done && result.read_number != 32'hFFFF_FFFF, !result_valid || result.read_number == $past(result.read_number) + 32'd1)

endmodule

`default_nettype wire

// ----- src/rbcf_front.sv -----
`default_nettype none

// Accepts items, classifies the base and applies the quality shift.
module rbcf_front (
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire rbcf_pkg::item_t item,
  input  wire rbcf_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output logic                 q_push,
  output rbcf_pkg::entry_t     q_entry
);
  import rbcf_pkg::*;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_entry.cls     = classify(item.base_char);
    q_entry.quality = item.quality_char + cfg.quality_shift;
    q_entry.last    = item.read_end;
  end

endmodule

`default_nettype wire

// ----- src/rbcf_queue.sv -----
`default_nettype none

// Small FIFO between classifier and accumulator.
module rbcf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rbcf_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output rbcf_pkg::entry_t      head
);
  import rbcf_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full       = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- src/rbcf_back.sv -----
`default_nettype none

// Counts classes, cross-multiplies limits by length, issues the verdict.
// Stages: accumulate -> multiply -> verdict/output register.
module rbcf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rbcf_pkg::cfg_t   cfg,
  input  wire logic             head_valid,
  input  wire rbcf_pkg::entry_t head,
  output logic                  pop,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output rbcf_pkg::result_t     result
);
  import rbcf_pkg::*;

  typedef struct packed {
    class_t                              cls;
    logic [7:0]                          quality;
    logic                                last;
    logic [NUM_CLS-1:0][LENGTH_BITS-1:0] cnt;
    logic [LENGTH_BITS-1:0]              len;
  } acc_stage_t;

  typedef struct packed {
    class_t                              cls;
    logic [7:0]                          quality;
    logic                                last;
    logic [NUM_CLS-1:0][LENGTH_BITS-1:0] cnt;
    logic [NUM_CLS-1:0][PROD_W-1:0]      prod;
  } mul_stage_t;

  logic [NUM_CLS-1:0][LENGTH_BITS-1:0] cnt;
  logic [NUM_CLS-1:0][LENGTH_BITS-1:0] cnt_next;
  logic [LENGTH_BITS-1:0]              len;
  logic [LENGTH_BITS-1:0]              len_next;
  acc_stage_t                          s1;
  logic                                s1_valid;
  mul_stage_t                          s2;
  logic                                s2_valid;
  logic [31:0]                         reads_seen;
  logic [31:0]                         reads_dropped;

  logic                 s1_ready;
  logic                 s2_ready;
  logic                 out_ready;
  logic                 s1_move;
  logic                 out_load;
  logic [NUM_CLS-1:0]   over;
  logic                 drop;
  logic [31:0]          number_next;
  logic [31:0]          dropped_next;

  assign out_ready = !result_valid || !result_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop       = head_valid && s1_ready;
  assign s1_move   = s1_valid && s2_ready;
  assign out_load  = s2_valid && out_ready;

  // saturating counts including the incoming base
  always_comb begin
    for (int i = 0; i < NUM_CLS; i++) begin
      cnt_next[i] = (head.cls == class_t'(i)) ? sat_inc_len(cnt[i]) : cnt[i];
    end
    len_next = sat_inc_len(len);
  end

  // A/C/G/T strictly over the limit, N at or over
  always_comb begin
    for (int i = 0; i < NUM_CLS; i++) begin
      if (i == int'(CLS_N)) begin
        over[i] = {1'b0, s2.cnt[i], {FRAC_W{1'b0}}} >= s2.prod[i];
      end else begin
        over[i] = {1'b0, s2.cnt[i], {FRAC_W{1'b0}}} > s2.prod[i];
      end
    end
    drop         = s2.last && (|over);
    number_next  = sat_inc32(reads_seen);
    dropped_next = drop ? sat_inc32(reads_dropped) : reads_dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      len           <= '0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      result_valid  <= 1'b0;
      reads_seen    <= '0;
      reads_dropped <= '0;
    end else begin
      if (pop) begin
        cnt <= head.last ? '0 : cnt_next;
        len <= head.last ? '0 : len_next;
      end
      if (s1_ready) begin
        s1_valid <= head_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        result_valid <= s2_valid;
      end
      if (out_load && s2.last) begin
        reads_seen    <= number_next;
        reads_dropped <= dropped_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1.cls     <= head.cls;
      s1.quality <= head.quality;
      s1.last    <= head.last;
      s1.cnt     <= cnt_next;
      s1.len     <= len_next;
    end
    if (s1_move) begin
      s2.cls     <= s1.cls;
      s2.quality <= s1.quality;
      s2.last    <= s1.last;
      s2.cnt     <= s1.cnt;
      for (int i = 0; i < NUM_CLS; i++) begin
        s2.prod[i] <= {{LENGTH_BITS{1'b0}}, cfg.limit[i]} * {{LIMIT_W{1'b0}}, s1.len};
      end
    end
    if (out_load) begin
      result.base_out      <= class_char(s2.cls);
      result.quality_out   <= s2.quality;
      result.read_done     <= s2.last;
      result.keep_read     <= s2.last && !drop;
      result.read_number   <= number_next;
      result.dropped_total <= dropped_next;
    end
  end

endmodule

`default_nettype wire

// ----- dv/read_base_composition_filter_top_tb.sv -----
`default_nettype none

module read_base_composition_filter_top_tb;
  import rbcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_PAIRS    = 250;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   wr_en = 1'b0;
  logic [REG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;

  read_base_composition_filter_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // Tracks per-read base counts and running read totals, and holds the
  // expected output of every pair transferred in but not yet seen out.
  class composition_scoreboard;
    logic [LIMIT_W-1:0]     limit [NUM_CLS];
    logic [7:0]             shift;
    logic [LENGTH_BITS-1:0] class_count [NUM_CLS];
    logic [LENGTH_BITS-1:0] read_len;
    logic [31:0]            reads_seen;
    logic [31:0]            reads_dropped;
    result_t                pending_results [$];
    int                     errors;
    int                     pairs_checked;
    int                     kept_seen;
    int                     dropped_seen;

    function new();
      for (int k = 0; k < NUM_CLS; k++) begin
        limit[k]       = (k == CLS_N) ? LIMIT_N_RESET : LIMIT_ACGT_RESET;
        class_count[k] = '0;
      end
      shift         = '0;
      read_len      = '0;
      reads_seen    = '0;
      reads_dropped = '0;
      errors        = 0;
      pairs_checked = 0;
      kept_seen     = 0;
      dropped_seen  = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LIMIT_A, REG_LIMIT_C, REG_LIMIT_G, REG_LIMIT_T, REG_LIMIT_N: begin
          limit[idx] = data[LIMIT_W-1:0];
        end
        REG_QUALITY_SHIFT: begin
          shift = data[7:0];
        end
        default: ;
      endcase
    endfunction

    function class_t base_class(logic [7:0] c);
      case (c)
        CHAR_A, CHAR_LA: return CLS_A;
        CHAR_C, CHAR_LC: return CLS_C;
        CHAR_G, CHAR_LG: return CLS_G;
        CHAR_T, CHAR_LT: return CLS_T;
        default:         return CLS_N;
      endcase
    endfunction

    // A/C/G/T: drop when strictly over the limit; N: drop at or over it.
    function bit read_rejected();
      logic [63:0] scaled;
      logic [63:0] bound;
      bit          drop;
      drop = 1'b0;
      for (int k = 0; k < NUM_CLS; k++) begin
        scaled = 64'(class_count[k]) << 16;
        bound  = 64'(limit[k]) * 64'(read_len);
        if (k == CLS_N) drop |= (scaled >= bound);
        else            drop |= (scaled > bound);
      end
      return drop;
    endfunction

    function void predict_pair(item_t it);
      class_t  cls;
      result_t exp;
      bit      drop;
      cls = base_class(it.base_char);
      if (class_count[cls] != '1) class_count[cls] = class_count[cls] + 1'b1;
      if (read_len != '1) read_len = read_len + 1'b1;
      case (cls)
        CLS_A:   exp.base_out = CHAR_A;
        CLS_C:   exp.base_out = CHAR_C;
        CLS_G:   exp.base_out = CHAR_G;
        CLS_T:   exp.base_out = CHAR_T;
        default: exp.base_out = CHAR_N;
      endcase
      exp.quality_out = it.quality_char + shift;
      exp.read_done   = it.read_end;
      if (it.read_end) begin
        drop = read_rejected();
        if (reads_seen != '1) reads_seen = reads_seen + 1'b1;
        if (drop && reads_dropped != '1) reads_dropped = reads_dropped + 1'b1;
        exp.keep_read     = !drop;
        exp.read_number   = reads_seen;
        exp.dropped_total = reads_dropped;
        for (int k = 0; k < NUM_CLS; k++) class_count[k] = '0;
        read_len = '0;
      end else begin
        exp.keep_read     = 1'b0;
        exp.read_number   = (reads_seen == '1) ? reads_seen : reads_seen + 1'b1;
        exp.dropped_total = reads_dropped;
      end
      pending_results.push_back(exp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: %s expected %0h, got %0h", pairs_checked, name, want, got);
      end
    endfunction

    function void check_pair(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing outstanding: %0h", got);
        return;
      end
      exp = pending_results.pop_front();
      compare_field("base_out", 32'(exp.base_out), 32'(got.base_out));
      compare_field("quality_out", 32'(exp.quality_out), 32'(got.quality_out));
      compare_field("read_done", 32'(exp.read_done), 32'(got.read_done));
      compare_field("keep_read", 32'(exp.keep_read), 32'(got.keep_read));
      compare_field("read_number", exp.read_number, got.read_number);
      compare_field("dropped_total", exp.dropped_total, got.dropped_total);
      if (exp.read_done) begin
        if (exp.keep_read) kept_seen++;
        else               dropped_seen++;
      end
      pairs_checked++;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    function void close_out();
      if (pending_results.size() != 0) begin
        errors += pending_results.size();
        $display("%0d results never came out", pending_results.size());
      end
    endfunction
  endclass

  composition_scoreboard sb = new();

  int burst_left   = 0;
  int pairs_sent   = 0;
  int settings_run = 0;
  bit hold_request = 1'b0;

  // Receiver stall pattern: segments of random mode, plus one long hold on request.
  int stall_mode = 0;
  int seg_left   = 0;
  int hold_left  = 0;

  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall = 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left   = $urandom_range(4, 60);
      end
      seg_left--;
      case (stall_mode)
        0:       result_stall = 1'b0;                          // full-rate stretch
        1:       result_stall = ($urandom_range(0, 3) == 0);   // light backpressure
        2:       result_stall = ($urandom_range(0, 3) != 0);   // heavy backpressure
        default: result_stall = ~result_stall;                 // alternating stall
      endcase
    end
  end

  // Output side: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_pair(result);
  end

  // Watchdog: a run of cycles with no transfer on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending_count());
        $display("read_base_composition_filter_top test failed");
        $finish;
      end
    end
  end

  // Offers one pair and returns at the falling edge after its transfer.
  // Bursts of random length separated by short random gaps; the odd long
  // burst gives stretches with no sender idling at all.
  task automatic send_pair(input logic [7:0] b, input logic [7:0] q, input logic last);
    item_t it;
    it.base_char    = b;
    it.quality_char = q;
    it.read_end     = last;
    if (burst_left == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    sb.predict_pair(it);
    pairs_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  // Lowers valid and waits for every outstanding result.
  task automatic wait_for_results();
    item_valid = 1'b0;
    burst_left = 0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [LIMIT_W-1:0] la, input logic [LIMIT_W-1:0] lc,
                               input logic [LIMIT_W-1:0] lg, input logic [LIMIT_W-1:0] lt,
                               input logic [LIMIT_W-1:0] ln, input logic [7:0] qs);
    write_reg(REG_LIMIT_A, la);
    write_reg(REG_LIMIT_C, lc);
    write_reg(REG_LIMIT_G, lg);
    write_reg(REG_LIMIT_T, lt);
    write_reg(REG_LIMIT_N, ln);
    write_reg(REG_QUALITY_SHIFT, {{(CFG_DATA_W-8){1'b0}}, qs});
    wr_en = 1'b0;
    settings_run++;
  endtask

  function automatic logic [7:0] char_for_class(class_t c);
    bit lower;
    lower = 1'($urandom_range(0, 1));
    case (c)
      CLS_A:   return lower ? CHAR_LA : CHAR_A;
      CLS_C:   return lower ? CHAR_LC : CHAR_C;
      CLS_G:   return lower ? CHAR_LG : CHAR_G;
      CLS_T:   return lower ? CHAR_LT : CHAR_T;
      default: return lower ? 8'($urandom_range(0, 255)) : CHAR_N;
    endcase
  endfunction

  // Skewed composition pushes fractions across the limits from both sides.
  function automatic logic [7:0] pick_base(class_t bias, int bias_pct);
    if ($urandom_range(0, 99) < bias_pct) return char_for_class(bias);
    if ($urandom_range(0, 4) == 0)        return 8'($urandom_range(0, 255));
    return char_for_class(class_t'($urandom_range(0, 3)));
  endfunction

  // Mostly short reads, some medium, few up to 80 bases.
  task automatic send_random_read();
    int     length;
    int     pick;
    int     bias_pct;
    class_t bias;
    pick = $urandom_range(0, 9);
    if (pick < 7)      length = $urandom_range(1, 8);
    else if (pick < 9) length = $urandom_range(9, 30);
    else               length = $urandom_range(31, 80);
    bias     = class_t'($urandom_range(0, 4));
    bias_pct = $urandom_range(0, 100);
    for (int i = 0; i < length; i++)
      send_pair(pick_base(bias, bias_pct), 8'($urandom_range(0, 255)), i == length - 1);
  endtask

  function automatic logic [LIMIT_W-1:0] random_limit();
    if ($urandom_range(0, 5) == 0) return LIMIT_W'($urandom_range(0, 131071));
    return LIMIT_W'($urandom_range(16384, 65536));
  endfunction

  initial begin
    int          phase_start;
    bit          hold_done;
    bit          pause_done;
    logic [7:0]  mixed_read [10];
    hold_done  = 1'b0;
    pause_done = 1'b0;
    mixed_read = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT,
                   CHAR_A, CHAR_C};

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed, reset limits: every class in both cases, non-base codes at
    // both ends of the byte, quality extremes.
    send_pair(CHAR_A,  8'h00, 1'b0);
    send_pair(CHAR_LC, 8'hFF, 1'b0);
    send_pair(CHAR_G,  8'h5A, 1'b0);
    send_pair(CHAR_LT, 8'hA5, 1'b0);
    send_pair(CHAR_N,  8'h21, 1'b0);
    send_pair(8'h6E,   8'h7E, 1'b0);  // lower-case n still counts as N
    send_pair(8'h00,   8'h80, 1'b0);
    send_pair(8'hFF,   8'h7F, 1'b0);
    send_pair(CHAR_LA, 8'h01, 1'b0);
    send_pair(CHAR_C,  8'hFE, 1'b0);
    send_pair(CHAR_LG, 8'h40, 1'b0);
    send_pair(CHAR_T,  8'hC0, 1'b1);
    // one-base reads: all N, then all G
    send_pair(CHAR_N, 8'h49, 1'b1);
    send_pair(CHAR_G, 8'h49, 1'b1);
    // balanced read that passes
    for (int i = 0; i < 10; i++) send_pair(mixed_read[i], 8'h28 + 8'(i), i == 9);

    for (int ph = 0; ph < 5; ph++) begin
      wait_for_results();
      case (ph)
        0: apply_setting('0, '0, '0, '0, 17'd65536, 8'h80);
        1: apply_setting(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'h1FFFF, 8'h7F);
        2: apply_setting(17'd32768, 17'd32768, 17'd32768, 17'd32768, 17'd16384, 8'h21);
        default: apply_setting(random_limit(), random_limit(), random_limit(),
                               random_limit(), LIMIT_W'($urandom_range(0, 32768)),
                               8'($urandom_range(0, 255)));
      endcase
      phase_start = pairs_sent;
      while (pairs_sent - phase_start < PHASE_PAIRS) begin
        send_random_read();
        // long receiver hold while items keep coming: fills the block
        if (ph == 1 && !hold_done && pairs_sent - phase_start > 60) begin
          hold_request = 1'b1;
          hold_done    = 1'b1;
        end
        // sender pause until the block has emptied
        if (ph == 2 && !pause_done && pairs_sent - phase_start > 120) begin
          wait_for_results();
          pause_done = 1'b1;
        end
      end
    end

    // back at reset limits for a last few reads
    wait_for_results();
    apply_setting(LIMIT_ACGT_RESET, LIMIT_ACGT_RESET, LIMIT_ACGT_RESET, LIMIT_ACGT_RESET,
                  LIMIT_N_RESET, 8'h00);
    repeat (5) send_random_read();

    wait_for_results();
    repeat (10) @(posedge clk);
    sb.close_out();
    $display("checked %0d pairs: %0d reads kept, %0d dropped, %0d limit/shift settings,",
             sb.pairs_checked, sb.kept_seen, sb.dropped_seen, settings_run);
    $display("including one long output hold and one full drain in mid-stream");
    if (sb.errors == 0) begin
      $display("read_base_composition_filter_top test passed");
    end else begin
      $display("read_base_composition_filter_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
